[sv/arc_pkg.sv]
// arc_pkg: shared types and constants for the arp cache and responder
// no dependencies; used by the top level, the checker and the bench
package arc_pkg;

  // command kinds
  localparam logic [2:0] KIND_RX      = 3'd0;
  localparam logic [2:0] KIND_RESOLVE = 3'd1;
  localparam logic [2:0] KIND_ADD     = 3'd2;
  localparam logic [2:0] KIND_DELETE  = 3'd3;
  localparam logic [2:0] KIND_STAT    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // transmit kinds
  localparam logic [1:0] TX_NONE    = 2'd0;
  localparam logic [1:0] TX_REQUEST = 2'd1;
  localparam logic [1:0] TX_REPLY   = 2'd2;

  // arp header checks
  localparam logic [15:0] MIN_LEN    = 16'd28;
  localparam logic [15:0] HW_ETHER   = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [7:0]  HW_LEN     = 8'd6;
  localparam logic [7:0]  PROTO_LEN  = 8'd4;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [15:0] OP_REPLY   = 16'h0002;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  // statistics counters
  localparam int NSTAT = 6;
  localparam logic [2:0] STAT_REQ_SENT = 3'd0;
  localparam logic [2:0] STAT_REP_SENT = 3'd1;
  localparam logic [2:0] STAT_REQ_RCVD = 3'd2;
  localparam logic [2:0] STAT_REP_RCVD = 3'd3;
  localparam logic [2:0] STAT_HITS     = 3'd4;
  localparam logic [2:0] STAT_MISSES   = 3'd5;
  localparam logic [2:0] STAT_COUNT    = 3'd6;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

  typedef struct packed {
    logic        valid;
    logic        stat;
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] resolved_mac;
    logic [1:0]  tx_kind;
    logic [47:0] tx_dest_mac;
    logic [31:0] tx_dst_ip;
    logic [63:0] stat_value;
  } result_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY
  } state_t;

endpackage

[sv/arc_if.sv]
// arc_if: valid/ready channels for command words and result words
// depends on nothing; widths follow the command and result fields
interface arc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] frame_length;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_addr_len;
  logic [7:0]  proto_addr_len;
  logic [15:0] arp_opcode;
  logic [47:0] src_mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [31:0] key_ip;
  logic [2:0]  stat_index;

  modport source(output valid, kind, frame_length, hw_type, proto_type, hw_addr_len,
                 proto_addr_len, arp_opcode, src_mac, src_ip, dst_ip, key_ip,
                 stat_index, input ready);
  modport sink(input valid, kind, frame_length, hw_type, proto_type, hw_addr_len,
               proto_addr_len, arp_opcode, src_mac, src_ip, dst_ip, key_ip,
               stat_index, output ready);
endinterface

interface arc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] resolved_mac;
  logic [1:0]  tx_kind;
  logic [47:0] tx_dest_mac;
  logic [31:0] tx_dst_ip;
  logic [63:0] stat_value;

  modport source(output valid, status, resolved_mac, tx_kind, tx_dest_mac, tx_dst_ip,
                 stat_value, input ready);
  modport sink(input valid, status, resolved_mac, tx_kind, tx_dest_mac, tx_dst_ip,
               stat_value, output ready);
endinterface

[sv/arc_bucket_hash.sv]
// arc_bucket_hash: bucket index = ip mod BUCKETS for any bucket count
// byte-wise residue tables built at elaboration, summed and folded; no package use
module arc_bucket_hash #(
  parameter int BUCKETS = 256
) (
  input  logic [31:0]                                  ip,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [BW+1:0] B1 = (BW+2)'(BUCKETS);
  localparam logic [BW+1:0] B2 = (BW+2)'(2 * BUCKETS);

  // residue of (byte value << 8k) for every byte position k
  logic [BW-1:0] tab [4][256];

  for (genvar k = 0; k < 4; k++) begin : g_pos
    for (genvar v = 0; v < 256; v++) begin : g_val
      localparam longint RES = (longint'(v) << (8 * k)) % BUCKETS;
      assign tab[k][v] = BW'(RES);
    end
  end

  logic [BW+1:0] sum;
  logic [BW+1:0] fold1;
  logic [BW+1:0] fold2;

  // four residues sum below 4*BUCKETS, two conditional subtracts finish it
  always_comb begin
    sum   = (BW+2)'(tab[0][ip[7:0]]) + (BW+2)'(tab[1][ip[15:8]])
          + (BW+2)'(tab[2][ip[23:16]]) + (BW+2)'(tab[3][ip[31:24]]);
    fold1 = (sum >= B2) ? sum - B2 : sum;
    fold2 = (fold1 >= B1) ? fold1 - B1 : fold1;
    bucket = BW'(fold2);
  end

endmodule

[sv/arp_cache_and_responder_unit.sv]
// arp_cache_and_responder_unit: one command word in, one registered result word out
// one command at a time: bucket row read, then modify and write-back of the same row in
// the single-port row memory; modify waits while the result register is still full
// reset (synchronous, active high) clears counters and config, then sweeps every row
// of the row memory with cmd.ready low; config writes are taken during the sweep
// depends on arc_pkg, arc_if, arc_bucket_hash
module arp_cache_and_responder_unit #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  arc_cmd_if.sink                          cmd,
  arc_res_if.source                        res,
  input  logic                             cfg_we,
  input  logic [arc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

  typedef arc_pkg::entry_t [WAYS-1:0] row_t;

  // configuration
  logic [31:0] own_ip;
  logic [47:0] own_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        arc_pkg::CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        arc_pkg::CFG_OWN_MAC: own_mac <= cfg_data;
        default: ;
      endcase
    end
  end

  // own_mac only goes into sent frames, which are outside this block's result
  logic own_mac_unused;
  assign own_mac_unused = ^own_mac;

  // control
  arc_pkg::state_t state, state_next;
  logic [BW-1:0]   clr_cnt;
  logic            accept;
  logic            commit;
  logic            out_free;

  // captured command word
  logic [2:0]  kind;
  logic        hdr_ok;
  logic [15:0] opcode;
  logic [47:0] mac;
  logic [31:0] key;
  logic [31:0] tgt_ip;
  logic [2:0]  stat_idx;
  logic [BW-1:0] bkt;

  logic [31:0]   cmd_key;
  logic [BW-1:0] cmd_bkt;

  // row memory
  row_t          mem [BUCKETS];
  row_t          rd_row;
  row_t          wr_row;
  row_t          mod_row;
  logic          mem_we;
  logic          row_dirty;
  logic [BW-1:0] wr_addr;

  // result register
  arc_pkg::result_t res_q, res_next;
  logic             res_valid;

  // statistics
  logic [63:0]               stat_cnt [arc_pkg::NSTAT];
  logic [arc_pkg::NSTAT-1:0] stat_inc;

  assign cmd_key = (cmd.kind == arc_pkg::KIND_RX) ? cmd.src_ip : cmd.key_ip;

  arc_bucket_hash #(.BUCKETS(BUCKETS)) u_hash (
    .ip     (cmd_key),
    .bucket (cmd_bkt)
  );

  assign out_free = !res_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= arc_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == arc_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    commit     = 1'b0;
    cmd.ready  = 1'b0;
    case (state)
      arc_pkg::S_CLEAR: begin
        if (clr_cnt == LAST_ROW) begin
          state_next = arc_pkg::S_IDLE;
        end
      end
      arc_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          accept     = 1'b1;
          state_next = arc_pkg::S_MODIFY;
        end
      end
      arc_pkg::S_MODIFY: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = arc_pkg::S_IDLE;
        end
      end
      default: state_next = arc_pkg::S_CLEAR;
    endcase
  end

  // capture the command and start the bucket read in the same cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      kind     <= cmd.kind;
      hdr_ok   <= (cmd.frame_length >= arc_pkg::MIN_LEN) &&
                  (cmd.hw_type == arc_pkg::HW_ETHER) &&
                  (cmd.proto_type == arc_pkg::PROTO_IPV4) &&
                  (cmd.hw_addr_len == arc_pkg::HW_LEN) &&
                  (cmd.proto_addr_len == arc_pkg::PROTO_LEN);
      opcode   <= cmd.arp_opcode;
      mac      <= cmd.src_mac;
      key      <= cmd_key;
      tgt_ip   <= cmd.dst_ip;
      stat_idx <= cmd.stat_index;
      bkt      <= cmd_bkt;
      rd_row   <= mem[cmd_bkt];
    end
  end

  assign mem_we  = (state == arc_pkg::S_CLEAR) || (commit && row_dirty);
  assign wr_addr = (state == arc_pkg::S_CLEAR) ? clr_cnt : bkt;
  assign wr_row  = (state == arc_pkg::S_CLEAR) ? row_t'('0) : mod_row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // way match and first free way
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] free_vec;
  logic [WW-1:0]   hit_idx;
  logic [WW-1:0]   free_idx;
  logic            any_hit;
  logic            any_free;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_row[w].valid && (rd_row[w].ip == key);
      free_vec[w] = !rd_row[w].valid;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WW'(w);
      end
      if (free_vec[w]) begin
        free_idx = WW'(w);
      end
    end
    any_hit  = |hit_vec;
    any_free = |free_vec;
  end

  // modify: result word, row update and counter bumps
  logic do_insert;
  logic ins_static;

  always_comb begin
    res_next   = '0;
    mod_row    = rd_row;
    row_dirty  = 1'b0;
    stat_inc   = '0;
    do_insert  = 1'b0;
    ins_static = 1'b0;
    case (kind)
      arc_pkg::KIND_RX: begin
        if (!hdr_ok) begin
          res_next.status = arc_pkg::ST_BAD;
        end else begin
          do_insert = 1'b1;
          if (opcode == arc_pkg::OP_REQUEST) begin
            stat_inc[arc_pkg::STAT_REQ_RCVD] = 1'b1;
            if (tgt_ip == own_ip) begin
              res_next.tx_kind     = arc_pkg::TX_REPLY;
              res_next.tx_dest_mac = mac;
              res_next.tx_dst_ip   = key;
              stat_inc[arc_pkg::STAT_REP_SENT] = 1'b1;
            end
          end else if (opcode == arc_pkg::OP_REPLY) begin
            stat_inc[arc_pkg::STAT_REP_RCVD] = 1'b1;
          end
        end
      end
      arc_pkg::KIND_RESOLVE: begin
        if (any_hit) begin
          res_next.resolved_mac = rd_row[hit_idx].mac;
          stat_inc[arc_pkg::STAT_HITS] = 1'b1;
        end else begin
          res_next.status      = arc_pkg::ST_MISS;
          res_next.tx_kind     = arc_pkg::TX_REQUEST;
          res_next.tx_dest_mac = arc_pkg::MAC_BCAST;
          res_next.tx_dst_ip   = key;
          stat_inc[arc_pkg::STAT_MISSES]   = 1'b1;
          stat_inc[arc_pkg::STAT_REQ_SENT] = 1'b1;
        end
      end
      arc_pkg::KIND_ADD: begin
        do_insert  = 1'b1;
        ins_static = 1'b1;
      end
      arc_pkg::KIND_DELETE: begin
        if (any_hit) begin
          mod_row[hit_idx].valid = 1'b0;
          row_dirty = 1'b1;
        end
      end
      arc_pkg::KIND_STAT: begin
        if (stat_idx < arc_pkg::STAT_COUNT) begin
          res_next.stat_value = stat_cnt[stat_idx];
        end
      end
      default: ;
    endcase

    // update in place on a match, else take the lowest free way
    if (do_insert) begin
      if (any_hit) begin
        mod_row[hit_idx].mac  = mac;
        mod_row[hit_idx].stat = ins_static;
        row_dirty = 1'b1;
      end else if (any_free) begin
        mod_row[free_idx].valid = 1'b1;
        mod_row[free_idx].stat  = ins_static;
        mod_row[free_idx].ip    = key;
        mod_row[free_idx].mac   = mac;
        row_dirty = 1'b1;
      end else begin
        res_next.status = arc_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < arc_pkg::NSTAT; i++) begin
      if (rst) begin
        stat_cnt[i] <= '0;
      end else if (commit && stat_inc[i]) begin
        stat_cnt[i] <= stat_cnt[i] + 64'd1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_q <= res_next;
    end
  end

  assign res.valid        = res_valid;
  assign res.status       = res_q.status;
  assign res.resolved_mac = res_q.resolved_mac;
  assign res.tx_kind      = res_q.tx_kind;
  assign res.tx_dest_mac  = res_q.tx_dest_mac;
  assign res.tx_dst_ip    = res_q.tx_dst_ip;
  assign res.stat_value   = res_q.stat_value;

endmodule

[sv/arc_checker.sv]
// arc_checker: port-level checks on the arp cache and responder, bound to the top level
// depends on arc_pkg and arc_if
module arc_checker (
  input logic       clk,
  input logic       rst,
  arc_cmd_if.sink   cmd,
  arc_res_if.source res
);

  // reset leaves no result word pending
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result word valid right after reset");

  // row memory sweep follows reset, no command taken in the first cycle after it
  a_clear_after_reset: assert property (@(posedge clk) (!rst && $past(rst)) |-> !cmd.ready)
    else $error("command taken while the cache is being cleared");

  // one command at a time: the cycle after an accept is the modify cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second command accepted during modify");

  // a stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> (res.valid && $stable(res.status) &&
                                   $stable(res.tx_kind) && $stable(res.stat_value)))
    else $error("result word changed while stalled");

  // a dropped header sends nothing and reads no counter
  a_bad_is_silent: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == arc_pkg::ST_BAD) |->
      (res.tx_kind == arc_pkg::TX_NONE && res.stat_value == 64'd0 &&
       res.resolved_mac == 48'd0))
    else $error("malformed header produced output");

endmodule

bind arp_cache_and_responder_unit arc_checker u_arc_checker (
  .clk (clk),
  .rst (rst),
  .cmd (cmd),
  .res (res)
);

[sim/tb_arp_cache_and_responder_unit.sv]
// tb_arp_cache_and_responder_unit: self-checking bench for the arp cache and responder
// predicts every result word from its own copy of the cache, counters and config
// depends on arc_pkg, arc_if and arp_cache_and_responder_unit
module tb_arp_cache_and_responder_unit;
  import arc_pkg::*;

  localparam int BUCKETS      = 256;
  localparam int WAYS         = 4;
  localparam int ENTRIES      = BUCKETS * WAYS;
  localparam int LIMIT        = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 140;
  localparam int POOL_SIZE    = 20;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] frame_length;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_addr_len;
    logic [7:0]  proto_addr_len;
    logic [15:0] arp_opcode;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [31:0] key_ip;
    logic [2:0]  stat_index;
  } arp_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arc_cmd_if cmd_ch();
  arc_res_if res_ch();

  arp_cache_and_responder_unit #(
    .BUCKETS(BUCKETS),
    .WAYS(WAYS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the cache, counters and config
  logic        ent_valid [ENTRIES];
  logic [31:0] ent_ip    [ENTRIES];
  logic [47:0] ent_mac   [ENTRIES];
  logic        ent_static[ENTRIES];
  logic [63:0] stat_count[NSTAT];
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;

  result_t     arp_results_due[$];
  result_t     res_want;
  logic [31:0] ip_pool[POOL_SIZE];
  int unsigned errors;
  bit          idle_on;
  bit          hold_req;
  int          hold_left;
  int          rx_gap;

  function automatic int cache_find(input logic [31:0] ip);
    int base;
    base = (ip % BUCKETS) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (ent_valid[base + w] && ent_ip[base + w] == ip) return base + w;
    end
    return -1;
  endfunction

  // update in place, else take the first free way; 0 when the bucket is full
  function automatic bit cache_store(input logic [31:0] ip, input logic [47:0] mac,
                                     input logic is_static);
    int hit;
    int base;
    hit = cache_find(ip);
    if (hit >= 0) begin
      ent_mac[hit]    = mac;
      ent_static[hit] = is_static;
      return 1'b1;
    end
    base = (ip % BUCKETS) * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (!ent_valid[base + w]) begin
        ent_valid[base + w]  = 1'b1;
        ent_ip[base + w]     = ip;
        ent_mac[base + w]    = mac;
        ent_static[base + w] = is_static;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t arp_predict(input arp_cmd_t c);
    result_t r;
    int hit;
    r = '0;
    case (c.kind)
      KIND_RX: begin
        if (c.frame_length < MIN_LEN || c.hw_type != HW_ETHER || c.proto_type != PROTO_IPV4 ||
            c.hw_addr_len != HW_LEN || c.proto_addr_len != PROTO_LEN) begin
          r.status = ST_BAD;
        end else begin
          if (!cache_store(c.src_ip, c.src_mac, 1'b0)) r.status = ST_FULL;
          if (c.arp_opcode == OP_REQUEST) begin
            stat_count[STAT_REQ_RCVD]++;
            if (c.dst_ip == own_ip_q) begin
              r.tx_kind     = TX_REPLY;
              r.tx_dest_mac = c.src_mac;
              r.tx_dst_ip   = c.src_ip;
              stat_count[STAT_REP_SENT]++;
            end
          end else if (c.arp_opcode == OP_REPLY) begin
            stat_count[STAT_REP_RCVD]++;
          end
        end
      end
      KIND_RESOLVE: begin
        hit = cache_find(c.key_ip);
        if (hit >= 0) begin
          r.resolved_mac = ent_mac[hit];
          stat_count[STAT_HITS]++;
        end else begin
          r.status      = ST_MISS;
          r.tx_kind     = TX_REQUEST;
          r.tx_dest_mac = MAC_BCAST;
          r.tx_dst_ip   = c.key_ip;
          stat_count[STAT_MISSES]++;
          stat_count[STAT_REQ_SENT]++;
        end
      end
      KIND_ADD: begin
        if (!cache_store(c.key_ip, c.src_mac, 1'b1)) r.status = ST_FULL;
      end
      KIND_DELETE: begin
        hit = cache_find(c.key_ip);
        if (hit >= 0) ent_valid[hit] = 1'b0;
      end
      KIND_STAT: begin
        if (c.stat_index < STAT_COUNT) r.stat_value = stat_count[c.stat_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (arp_results_due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing due, expected none actual status %h tx %h",
                 $time, res_ch.status, res_ch.tx_kind);
      end else begin
        res_want = arp_results_due.pop_front();
        check_field("status", res_want.status, res_ch.status);
        check_field("resolved_mac", res_want.resolved_mac, res_ch.resolved_mac);
        check_field("tx_kind", res_want.tx_kind, res_ch.tx_kind);
        check_field("tx_dest_mac", res_want.tx_dest_mac, res_ch.tx_dest_mac);
        check_field("tx_dst_ip", res_want.tx_dst_ip, res_ch.tx_dst_ip);
        check_field("stat_value", res_want.stat_value, res_ch.stat_value);
      end
      rx_gap = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  // receiver: long hold-off on request, else a random gap after each word
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else if (rx_gap > 0) begin
      res_ch.ready <= 1'b0;
      rx_gap--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // returns at the rising edge that took the word
  task automatic send_cmd(input arp_cmd_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.kind           <= c.kind;
    cmd_ch.frame_length   <= c.frame_length;
    cmd_ch.hw_type        <= c.hw_type;
    cmd_ch.proto_type     <= c.proto_type;
    cmd_ch.hw_addr_len    <= c.hw_addr_len;
    cmd_ch.proto_addr_len <= c.proto_addr_len;
    cmd_ch.arp_opcode     <= c.arp_opcode;
    cmd_ch.src_mac        <= c.src_mac;
    cmd_ch.src_ip         <= c.src_ip;
    cmd_ch.dst_ip         <= c.dst_ip;
    cmd_ch.key_ip         <= c.key_ip;
    cmd_ch.stat_index     <= c.stat_index;
    cmd_ch.valid          <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    arp_results_due.push_back(arp_predict(c));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (arp_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == CFG_OWN_IP) own_ip_q = data[31:0];
    else own_mac_q = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_phase(input logic [31:0] ip, input logic [47:0] mac);
    wait_drain();
    write_cfg(CFG_OWN_IP, CFG_DATA_W'(ip));
    write_cfg(CFG_OWN_MAC, mac);
  endtask

  function automatic arp_cmd_t arp_hdr(input logic [15:0] op, input logic [47:0] smac,
                                       input logic [31:0] sip, input logic [31:0] tip);
    arp_cmd_t c;
    c                = '0;
    c.kind           = KIND_RX;
    c.frame_length   = MIN_LEN;
    c.hw_type        = HW_ETHER;
    c.proto_type     = PROTO_IPV4;
    c.hw_addr_len    = HW_LEN;
    c.proto_addr_len = PROTO_LEN;
    c.arp_opcode     = op;
    c.src_mac        = smac;
    c.src_ip         = sip;
    c.dst_ip         = tip;
    return c;
  endfunction

  function automatic arp_cmd_t cache_cmd(input logic [2:0] kind, input logic [31:0] key,
                                         input logic [47:0] mac, input logic [2:0] idx);
    arp_cmd_t c;
    c            = '0;
    c.kind       = kind;
    c.key_ip     = key;
    c.src_mac    = mac;
    c.stat_index = idx;
    return c;
  endfunction

  function automatic logic [31:0] pick_ip();
    if ($urandom_range(0, 99) < 88) return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic arp_cmd_t random_cmd();
    arp_cmd_t c;
    int roll;
    c.kind           = 3'($urandom);
    c.frame_length   = 16'($urandom);
    c.hw_type        = 16'($urandom);
    c.proto_type     = 16'($urandom);
    c.hw_addr_len    = 8'($urandom);
    c.proto_addr_len = 8'($urandom);
    c.arp_opcode     = 16'($urandom);
    c.src_mac        = 48'({$urandom, $urandom});
    c.src_ip         = $urandom;
    c.dst_ip         = $urandom;
    c.key_ip         = $urandom;
    c.stat_index     = 3'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 42) begin
      c.kind   = KIND_RX;
      c.src_ip = pick_ip();
      c.dst_ip = $urandom_range(0, 1) ? own_ip_q : pick_ip();
      if ($urandom_range(0, 99) < 85) begin
        c.hw_type        = HW_ETHER;
        c.proto_type     = PROTO_IPV4;
        c.hw_addr_len    = HW_LEN;
        c.proto_addr_len = PROTO_LEN;
        case ($urandom_range(0, 3))
          0: c.frame_length = MIN_LEN;
          1: c.frame_length = 16'hFFFF;
          default: c.frame_length = 16'($urandom_range(MIN_LEN, 16'hFFFF));
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 45) c.arp_opcode = OP_REQUEST;
        else if (roll < 80) c.arp_opcode = OP_REPLY;
      end else begin
        // broken header: one check fails, or hw_type is left as noise
        c.frame_length   = 16'($urandom_range(MIN_LEN, 16'hFFFF));
        c.hw_type        = HW_ETHER;
        c.proto_type     = PROTO_IPV4;
        c.hw_addr_len    = HW_LEN;
        c.proto_addr_len = PROTO_LEN;
        case ($urandom_range(0, 5))
          0: c.frame_length = 16'($urandom_range(0, MIN_LEN - 1));
          1: c.hw_type = HW_ETHER ^ 16'($urandom_range(1, 16'hFFFF));
          2: c.proto_type = PROTO_IPV4 ^ 16'($urandom_range(1, 16'hFFFF));
          3: c.hw_addr_len = HW_LEN ^ 8'($urandom_range(1, 8'hFF));
          4: c.proto_addr_len = PROTO_LEN ^ 8'($urandom_range(1, 8'hFF));
          default: c.hw_type = 16'($urandom);
        endcase
      end
    end else if (roll < 67) begin
      c.kind   = KIND_RESOLVE;
      c.key_ip = pick_ip();
    end else if (roll < 79) begin
      c.kind   = KIND_ADD;
      c.key_ip = pick_ip();
    end else if (roll < 93) begin
      c.kind   = KIND_DELETE;
      c.key_ip = pick_ip();
    end else if (roll < 97) begin
      c.kind = KIND_STAT;
    end else begin
      c.kind = 3'($urandom_range(KIND_STAT + 1, KIND_UNUSED));
    end
    return c;
  endfunction

  task automatic test_header_checks();
    arp_cmd_t c;
    c = arp_hdr(OP_REQUEST, 48'h0200_0000_0011, 32'h0A00_0111, own_ip_q);
    c.frame_length = MIN_LEN - 1;
    send_cmd(c);
    c = arp_hdr(OP_REQUEST, 48'h0200_0000_0011, 32'h0A00_0111, own_ip_q);
    c.hw_type = 16'h0000;
    send_cmd(c);
    c = arp_hdr(OP_REQUEST, 48'h0200_0000_0011, 32'h0A00_0111, own_ip_q);
    c.proto_type = 16'hFFFF;
    send_cmd(c);
    c = arp_hdr(OP_REQUEST, 48'h0200_0000_0011, 32'h0A00_0111, own_ip_q);
    c.hw_addr_len = 8'hFF;
    send_cmd(c);
    c = arp_hdr(OP_REQUEST, 48'h0200_0000_0011, 32'h0A00_0111, own_ip_q);
    c.proto_addr_len = 8'h00;
    send_cmd(c);
    // shortest legal length, unknown opcode only learns the sender
    send_cmd(arp_hdr(16'hFFFF, 48'h0, 32'h0A00_0105, own_ip_q));
  endtask

  task automatic test_request_reply();
    arp_cmd_t c;
    c = arp_hdr(OP_REQUEST, MAC_BCAST, 32'hC0A8_0A21, own_ip_q);
    c.frame_length = 16'hFFFF;
    send_cmd(c);
    send_cmd(arp_hdr(OP_REQUEST, 48'h0200_0000_0022, 32'hC0A8_0A22, ~own_ip_q));
    send_cmd(arp_hdr(OP_REPLY, 48'h0200_0000_0023, 32'hC0A8_0A23, own_ip_q));
  endtask

  task automatic test_resolve();
    send_cmd(cache_cmd(KIND_RESOLVE, 32'h0A00_0105, 48'h0, STAT_REQ_SENT));
    send_cmd(cache_cmd(KIND_RESOLVE, 32'h0000_0000, 48'h0, STAT_REQ_SENT));
  endtask

  task automatic test_static_delete();
    send_cmd(cache_cmd(KIND_ADD, 32'h0A00_0133, 48'h0600_DEAD_BEEF, STAT_REQ_SENT));
    send_cmd(cache_cmd(KIND_RESOLVE, 32'h0A00_0133, 48'h0, STAT_REQ_SENT));
    send_cmd(cache_cmd(KIND_DELETE, 32'h0A00_0133, 48'h0, STAT_REQ_SENT));
    // delete of an address no longer cached
    send_cmd(cache_cmd(KIND_DELETE, 32'h0A00_0133, 48'h0, STAT_REQ_SENT));
  endtask

  task automatic test_bucket_full();
    logic [31:0] ip;
    for (int i = 1; i <= WAYS + 1; i++) begin
      ip = 32'h0000_00FF | (32'(i) << 24);
      send_cmd(cache_cmd(KIND_ADD, ip, (i == 1) ? MAC_BCAST : 48'(i - 2), STAT_REQ_SENT));
    end
    // reply still goes out when the learn is dropped
    send_cmd(arp_hdr(OP_REQUEST, 48'h0200_0000_00FF, 32'h0600_00FF, own_ip_q));
  endtask

  task automatic test_stats();
    send_cmd(cache_cmd(KIND_STAT, 32'h0, 48'h0, STAT_REQ_SENT));
    send_cmd(cache_cmd(KIND_STAT, 32'h0, 48'h0, STAT_MISSES));
    send_cmd(cache_cmd(KIND_STAT, 32'h0, 48'h0, STAT_COUNT));
    send_cmd(cache_cmd(KIND_UNUSED, 32'hFFFF_FFFF, MAC_BCAST, STAT_HITS));
  endtask

  task automatic test_backpressure();
    wait_drain();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) send_cmd(random_cmd());
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    logic [7:0] bucket_sel[4];
    bucket_sel[0] = 8'h00;
    bucket_sel[1] = 8'h7F;
    bucket_sel[2] = 8'($urandom);
    bucket_sel[3] = 8'($urandom);
    // few buckets, more addresses than ways, so hits and full buckets are common
    for (int i = 0; i < POOL_SIZE; i++) begin
      ip_pool[i]      = $urandom;
      ip_pool[i][7:0] = bucket_sel[i % 4];
    end
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_phase(32'h0, 48'h0);
        1: set_phase(32'hFFFF_FFFF, MAC_BCAST);
        default: set_phase($urandom, 48'({$urandom, $urandom}));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_cmd(random_cmd());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    errors    = 0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    hold_left = 0;
    rx_gap    = 0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    res_ch.ready          = 1'b0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.kind           = '0;
    cmd_ch.frame_length   = '0;
    cmd_ch.hw_type        = '0;
    cmd_ch.proto_type     = '0;
    cmd_ch.hw_addr_len    = '0;
    cmd_ch.proto_addr_len = '0;
    cmd_ch.arp_opcode     = '0;
    cmd_ch.src_mac        = '0;
    cmd_ch.src_ip         = '0;
    cmd_ch.dst_ip         = '0;
    cmd_ch.key_ip         = '0;
    cmd_ch.stat_index     = '0;
    for (int i = 0; i < ENTRIES; i++) ent_valid[i] = 1'b0;
    for (int i = 0; i < NSTAT; i++) stat_count[i] = '0;
    own_ip_q  = '0;
    own_mac_q = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    write_cfg(CFG_OWN_IP, CFG_DATA_W'(32'hC0A8_0001));
    write_cfg(CFG_OWN_MAC, 48'h0200_C0A8_0001);
    test_header_checks();
    test_request_reply();
    test_resolve();
    test_static_delete();
    test_bucket_full();
    test_stats();
    test_backpressure();
    test_random();
    wait_drain();

    if (arp_results_due.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, arp_results_due.size());
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
sv/arc_pkg.sv
sv/arc_if.sv
sv/arc_bucket_hash.sv
sv/arp_cache_and_responder_unit.sv
sv/arc_checker.sv
sim/tb_arp_cache_and_responder_unit.sv
